// ----- src/hcp_pkg.sv -----
// Shared constants and types for the heads-count probability unit.
package hcp_pkg;

    localparam int DEF_MAX_TARGET = 64;
    localparam int DEF_FRAC_BITS  = 24;
    localparam int TARGET_W       = 7;

    // Per-cycle commands broadcast from the sequencer to every cell.
    typedef struct packed {
        logic mul_en;
        logic upd_en;
        logic clear;
    } cell_ctrl_t;

endpackage

// ----- src/hcp_cell.sv -----
// One distribution entry of the head-count chain with its two products.
module hcp_cell #(
    parameter int FRAC_BITS = 24,
    parameter bit IS_FIRST  = 1'b0
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  hcp_pkg::cell_ctrl_t    ctrl_i,
    input  logic [FRAC_BITS:0]     left_i,
    input  logic [FRAC_BITS:0]     p_i,
    input  logic [FRAC_BITS:0]     q_i,
    output logic [FRAC_BITS:0]     entry_o
);
    import hcp_pkg::*;

    localparam int VAL_W  = FRAC_BITS + 1;
    localparam int PROD_W = 2 * VAL_W;
    localparam logic [VAL_W-1:0] ONE_VAL   = VAL_W'(1) << FRAC_BITS;
    localparam logic [VAL_W:0]   ONE_SUM   = (VAL_W + 1)'(1) << FRAC_BITS;
    localparam logic [VAL_W-1:0] RESET_VAL = IS_FIRST ? ONE_VAL : '0;

    logic [VAL_W-1:0]  entry_reg, entry_next;
    logic [VAL_W-1:0]  prod_left_reg, prod_self_reg;
    logic [PROD_W-1:0] left_full, self_full;
    logic [VAL_W:0]    sum;

    assign left_full = PROD_W'(left_i) * PROD_W'(p_i);
    assign self_full = PROD_W'(entry_reg) * PROD_W'(q_i);

    // Both operands never exceed 1.0, so the truncated products fit VAL_W bits.
    always_ff @(posedge aclk) begin
        if (ctrl_i.mul_en) begin
            prod_left_reg <= left_full[FRAC_BITS +: VAL_W];
            prod_self_reg <= self_full[FRAC_BITS +: VAL_W];
        end
    end

    assign sum = {1'b0, prod_left_reg} + {1'b0, prod_self_reg};

    always_comb begin
        entry_next = entry_reg;
        if (ctrl_i.clear) begin
            entry_next = RESET_VAL;
        end else if (ctrl_i.upd_en) begin
            entry_next = (sum > ONE_SUM) ? ONE_VAL : sum[VAL_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entry_reg <= RESET_VAL;
        end else begin
            entry_reg <= entry_next;
        end
    end

    assign entry_o = entry_reg;

endmodule

// ----- src/heads_count_probability_dp_unit.sv -----
// Top level of the heads-count probability unit: sequencer, chain of cells, output register.
//
// Usage: each transaction on the s_ channel carries one coin's heads probability
// (s_head_prob, fixed point with FRAC_BITS fraction bits, values above 1.0 are
// clipped to 1.0) and a flag s_last_coin. Every coin updates the whole head-count
// distribution held in a row of MAX_TARGET+1 cells. On the last coin of a set the
// entry at target_heads is sent as one transaction on the m_ channel and the
// distribution returns to "zero heads with certainty".
// Each ordinary coin passes through a multiply step (every cell forms its two
// products) and an add step (every cell adds and stores them); a new coin is taken
// in the add step of the previous one. After a last coin an output step reads the
// target entry into the output register and clears the cells, and the next coin is
// taken once the unit is back in idle; the output step waits while a result is untaken.
// m_valid is driven from the output register once the output step has loaded it.
// If the receiver stalls, the result waits in the output register; further coins
// are still taken, and only the next last coin waits until the register is free.
// The user must write target_heads through cfg_we/cfg_wdata while the unit is idle;
// the block does not enforce this. Reset (aresetn low, synchronous) empties the output
// register, sets target_heads to zero and loads the initial distribution into the cells.
module heads_count_probability_dp_unit #(
    parameter int MAX_TARGET = hcp_pkg::DEF_MAX_TARGET,
    parameter int FRAC_BITS  = hcp_pkg::DEF_FRAC_BITS
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [hcp_pkg::TARGET_W-1:0]  cfg_wdata,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [FRAC_BITS:0]            s_head_prob,
    input  logic                          s_last_coin,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [FRAC_BITS:0]            m_probability
);
    import hcp_pkg::*;

    localparam int VAL_W = FRAC_BITS + 1;
    localparam int IDX_W = (MAX_TARGET + 1 > 1) ? $clog2(MAX_TARGET + 1) : 1;
    localparam int CMP_W = ((IDX_W > TARGET_W) ? IDX_W : TARGET_W) + 1;
    localparam logic [VAL_W-1:0] ONE_VAL = VAL_W'(1) << FRAC_BITS;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_ADD,
        ST_OUT
    } state_t;

    state_t            state_reg, state_next;
    logic [TARGET_W-1:0] target_reg;
    logic [VAL_W-1:0]  p_reg, p_next;
    logic [VAL_W-1:0]  q_reg;
    logic              last_reg;
    logic              m_valid_reg, m_valid_next;
    logic [VAL_W-1:0]  m_prob_reg, m_prob_next;
    logic              s_accept;
    logic              out_load;
    cell_ctrl_t        ctrl;

    logic [CMP_W-1:0]  tgt_wide, tgt_clamped;
    logic [IDX_W-1:0]  tgt_idx;
    logic [VAL_W-1:0]  entry_chain [MAX_TARGET+1];

    // A new coin may enter while idle, or during the add cycle of an ordinary coin:
    // its products are formed in the following cycle, after the entries are stored.
    assign s_ready  = (state_reg == ST_IDLE) || ((state_reg == ST_ADD) && !last_reg);
    assign s_accept = s_valid && s_ready;
    assign out_load = (state_reg == ST_OUT) && (!m_valid_reg || m_ready);

    assign p_next = (s_head_prob > ONE_VAL) ? ONE_VAL : s_head_prob;

    // Targets beyond the end of the chain read the last cell.
    assign tgt_wide    = CMP_W'(target_reg);
    assign tgt_clamped = (tgt_wide > CMP_W'(MAX_TARGET)) ? CMP_W'(MAX_TARGET) : tgt_wide;
    assign tgt_idx     = tgt_clamped[IDX_W-1:0];

    always_comb begin
        state_next = state_reg;
        ctrl       = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                ctrl.mul_en = 1'b1;
                state_next  = ST_ADD;
            end
            ST_ADD: begin
                ctrl.upd_en = 1'b1;
                if (last_reg) begin
                    state_next = ST_OUT;
                end else if (s_accept) begin
                    state_next = ST_MUL;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_OUT: begin
                if (out_load) begin
                    ctrl.clear = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        m_prob_next  = m_prob_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
            m_prob_next  = entry_chain[tgt_idx];
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            target_reg  <= '0;
            last_reg    <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we) begin
                target_reg <= cfg_wdata;
            end
            if (s_accept) begin
                last_reg <= s_last_coin;
            end
        end
    end

    // Coin probability and its complement: payload only.
    always_ff @(posedge aclk) begin
        m_prob_reg <= m_prob_next;
        if (s_accept) begin
            p_reg <= p_next;
            q_reg <= ONE_VAL - p_next;
        end
    end

    // The chain: cell j takes the old value of cell j-1 from its neighbor.
    // Cell zero has no neighbor, so its left input is zero.
    for (genvar j = 0; j <= MAX_TARGET; j++) begin : g_cell
        logic [VAL_W-1:0] left_val;
        if (j == 0) begin : g_head
            assign left_val = '0;
        end else begin : g_body
            assign left_val = entry_chain[j-1];
        end
        hcp_cell #(
            .FRAC_BITS (FRAC_BITS),
            .IS_FIRST  (j == 0)
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .ctrl_i  (ctrl),
            .left_i  (left_val),
            .p_i     (p_reg),
            .q_i     (q_reg),
            .entry_o (entry_chain[j])
        );
    end

    assign m_valid       = m_valid_reg;
    assign m_probability = m_prob_reg;

`ifndef SYNTHESIS
    // After a last coin is taken, nothing else enters until its result is formed.
    a_last_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_last_coin) |=> !s_ready ##1 !s_ready)
        else $error("coin accepted while a last coin was still in the chain");

    // A result appears only from the output cycle of a last coin.
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_OUT))
        else $error("result raised outside the output cycle");

    // Loading a result restarts the distribution at zero heads.
    a_clear_after_load: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> (m_valid_reg && (entry_chain[0] == ONE_VAL)))
        else $error("distribution not restored after a result");

    // The read index never leaves the chain.
    a_index_range: assert property (@(posedge aclk) disable iff (!aresetn)
        tgt_clamped <= CMP_W'(MAX_TARGET))
        else $error("target index beyond the last cell");
`endif

endmodule
